>>> rtl/core/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants shared by the serial frame deframer modules.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] NullByte = 8'h00;
  localparam logic [ByteW-1:0] SohByte  = 8'h01;
  localparam logic [ByteW-1:0] EotByte  = 8'h04;
  localparam logic [ByteW-1:0] MinLen   = 8'd3;

  typedef enum logic [1:0] {
    ST_HUNT = 2'd0,
    ST_SOH  = 2'd1,
    ST_LEN  = 2'd2,
    ST_MSG  = 2'd3
  } parse_state_e;

  typedef enum logic [1:0] {
    KIND_ID      = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2
  } out_kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_CHECK = 2'd1,
    STAT_BAD_END   = 2'd2,
    STAT_BAD_LEN   = 2'd3
  } frame_status_e;

  typedef struct packed {
    out_kind_e        kind;
    logic [ByteW-1:0] data;
    frame_status_e    status;
    logic [ByteW-1:0] plen;
  } result_t;

endpackage

>>> rtl/core/sfd_in_stage.sv
// ----------------------------------------------------------------------------
// sfd_in_stage
// Input register holding one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module sfd_in_stage
  import sfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic             down_ready_i,
  output logic             step_o,
  output logic [ByteW-1:0] byte_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;

  assign step_o     = valid_q & down_ready_i;
  assign in_ready_o = ~valid_q | down_ready_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

endmodule

>>> rtl/core/sfd_parser.sv
// ----------------------------------------------------------------------------
// sfd_parser
// Frame state machine: hunts for null and soh, tracks length and checksum.
// ----------------------------------------------------------------------------
module sfd_parser
  import sfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  parse_state_e     state_q, state_d;
  logic [ByteW-1:0] rem_q, rem_d;
  logic [ByteW-1:0] flen_q, flen_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] chk_q, chk_d;
  logic [ByteW-1:0] rem_dec;
  logic [ByteW-1:0] expect_chk;

  assign rem_dec    = rem_q - 8'd1;
  assign expect_chk = 8'd0 - sum_q;

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    flen_d      = flen_q;
    sum_d       = sum_q;
    chk_d       = chk_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_ID, data: '0, status: STAT_OK, plen: '0};
    case (state_q)
      ST_HUNT: begin
        if (byte_i == NullByte) begin
          state_d = ST_SOH;
        end
      end
      ST_SOH: begin
        state_d = (byte_i == SohByte) ? ST_LEN : ST_HUNT;
      end
      ST_LEN: begin
        if (byte_i < MinLen) begin
          state_d      = ST_HUNT;
          rem_d        = '0;
          res_valid_o  = 1'b1;
          res_o.kind   = KIND_END;
          res_o.status = STAT_BAD_LEN;
        end else begin
          state_d = ST_MSG;
          flen_d  = byte_i;
          rem_d   = byte_i;
          sum_d   = byte_i;
          chk_d   = '0;
        end
      end
      ST_MSG: begin
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          state_d      = ST_HUNT;
          res_valid_o  = 1'b1;
          res_o.kind   = KIND_END;
          res_o.plen   = flen_q - MinLen;
          if (byte_i != EotByte) begin
            res_o.status = STAT_BAD_END;
          end else if (expect_chk != chk_q) begin
            res_o.status = STAT_BAD_CHECK;
          end else begin
            res_o.status = STAT_OK;
          end
        end else if (rem_dec == 8'd1) begin
          chk_d = byte_i;
        end else begin
          sum_d       = sum_q + byte_i;
          res_valid_o = 1'b1;
          res_o.data  = byte_i;
          res_o.kind  = (rem_q == flen_q) ? KIND_ID : KIND_PAYLOAD;
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      rem_q   <= '0;
      flen_q  <= '0;
      sum_q   <= '0;
      chk_q   <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      rem_q   <= rem_d;
      flen_q  <= flen_d;
      sum_q   <= sum_d;
      chk_q   <= chk_d;
    end
  end

endmodule

>>> rtl/core/sfd_out_stage.sv
// ----------------------------------------------------------------------------
// sfd_out_stage
// Result register holding one result until the consumer takes it.
// ----------------------------------------------------------------------------
module sfd_out_stage
  import sfd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  assign ready_o     = ~valid_q | out_ready_i;
  assign load        = step_i & res_valid_i;
  assign valid_d     = ready_o ? load : valid_q;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

endmodule

>>> rtl/core/serial_frame_deframer.sv
// ----------------------------------------------------------------------------
// serial_frame_deframer
// Finds null/soh framed messages in a byte stream, passes out the id and
// payload bytes and reports a frame-end status with the payload length.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------
//  input    | in_valid_i/in_ready_o | rx_byte_i
//  output   | out_valid_o/out_ready_i | out_kind_o out_byte_o frame_status_o
//           |                       | payload_length_o
//
// one byte per cycle sustained while the output does not stall; an accepted byte
// passes the input register, then its result is held in the result register
// bytes that give no result are consumed without touching the output side
// reset clears both stage valids and returns the parser to hunting
// a stalled output holds the result register and backs up into the input
// register, which then deasserts in_ready_o
// ----------------------------------------------------------------------------
module serial_frame_deframer
  import sfd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] rx_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       out_kind_o,
  output logic [ByteW-1:0] out_byte_o,
  output logic [1:0]       frame_status_o,
  output logic [ByteW-1:0] payload_length_o
);

  logic             step;
  logic             down_ready;
  logic [ByteW-1:0] cur_byte;
  logic             res_valid;
  result_t          res;
  result_t          res_out;

  sfd_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .down_ready_i(down_ready),
    .step_o      (step),
    .byte_o      (cur_byte)
  );

  sfd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (cur_byte),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  sfd_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .res_valid_i(res_valid),
    .res_i      (res),
    .ready_o    (down_ready),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res_out)
  );

  assign out_kind_o       = res_out.kind;
  assign out_byte_o       = res_out.data;
  assign frame_status_o   = res_out.status;
  assign payload_length_o = res_out.plen;

endmodule

>>> test/serial_frame_deframer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_frame_deframer_test
// Self-checking bench for the frame deframer. A short table of directed bytes
// covers hunting, a broken start, bad length, checksum and end-marker errors.
// Random frames follow, mostly well formed, some corrupted, truncated or
// mixed with noise. A bursty sender and a stalling receiver put gaps on both
// sides. Every result is compared field by field with the expected value from
// the directed table or from a software parser of the byte stream.
// ----------------------------------------------------------------------------
module serial_frame_deframer_test;
  import sfd_pkg::*;

  localparam int StreamItems   = 1850;
  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 6;

  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_NONE,
    CHK_LIT
  } check_e;

  typedef struct packed {
    logic [ByteW-1:0] rx;
    check_e           how;
    result_t          lit;
  } row_t;

  localparam row_t DirectedRows [25] = '{
    '{8'hFF, CHK_NONE, '0},
    '{8'h00, CHK_NONE, '0},
    '{8'h00, CHK_NONE, '0},
    '{8'h00, CHK_NONE, '0},
    '{8'h01, CHK_NONE, '0},
    '{8'h02, CHK_LIT,  '{KIND_END, 8'h00, STAT_BAD_LEN, 8'h00}},
    '{8'h00, CHK_NONE, '0},
    '{8'h01, CHK_NONE, '0},
    '{8'h03, CHK_NONE, '0},
    '{8'hFF, CHK_LIT,  '{KIND_ID, 8'hFF, STAT_OK, 8'h00}},
    '{8'hFE, CHK_NONE, '0},
    '{8'h04, CHK_LIT,  '{KIND_END, 8'h00, STAT_OK, 8'h00}},
    '{8'h00, CHK_NONE, '0},
    '{8'h01, CHK_NONE, '0},
    '{8'h04, CHK_NONE, '0},
    '{8'h80, CHK_PRED, '0},
    '{8'h00, CHK_PRED, '0},
    '{8'h7C, CHK_NONE, '0},
    '{8'hFF, CHK_LIT,  '{KIND_END, 8'h00, STAT_BAD_END, 8'h01}},
    '{8'h00, CHK_NONE, '0},
    '{8'h01, CHK_NONE, '0},
    '{8'h03, CHK_NONE, '0},
    '{8'h00, CHK_LIT,  '{KIND_ID, 8'h00, STAT_OK, 8'h00}},
    '{8'h00, CHK_NONE, '0},
    '{8'h04, CHK_LIT,  '{KIND_END, 8'h00, STAT_BAD_CHECK, 8'h00}}
  };

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  logic [ByteW-1:0] rx_byte        = '0;
  logic             out_valid;
  logic             out_ready      = 1'b0;
  logic [1:0]       out_kind;
  logic [ByteW-1:0] out_byte;
  logic [1:0]       frame_status;
  logic [ByteW-1:0] payload_length;

  // software parser state
  parse_state_e     pstate    = ST_HUNT;
  logic [ByteW-1:0] left_cnt  = '0;
  logic [ByteW-1:0] frame_len = '0;
  logic [ByteW-1:0] sum_acc   = '0;
  logic [ByteW-1:0] rx_check  = '0;

  result_t parsed_q [$];
  int      mismatch_count = 0;
  int      idle_cycles    = 0;
  int      burst_left     = 0;
  int      stream_items   = 0;
  logic [5:0]  ready_tick    = '0;
  logic [15:0] ready_pattern = '1;

  serial_frame_deframer dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .out_kind_o       (out_kind),
    .out_byte_o       (out_byte),
    .frame_status_o   (frame_status),
    .payload_length_o (payload_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit parse_byte(input logic [ByteW-1:0] b, output result_t r);
    logic [ByteW-1:0] pos;
    logic [ByteW-1:0] want_check;
    r = '0;
    case (pstate)
      ST_HUNT: begin
        if (b == NullByte) pstate = ST_SOH;
        return 1'b0;
      end
      ST_SOH: begin
        pstate = (b == SohByte) ? ST_LEN : ST_HUNT;
        return 1'b0;
      end
      ST_LEN: begin
        if (b < MinLen) begin
          pstate   = ST_HUNT;
          left_cnt = '0;
          r.kind   = KIND_END;
          r.status = STAT_BAD_LEN;
          return 1'b1;
        end
        frame_len = b;
        left_cnt  = b;
        sum_acc   = b;
        rx_check  = '0;
        pstate    = ST_MSG;
        return 1'b0;
      end
      default: ;
    endcase
    pos      = frame_len - left_cnt;
    left_cnt = left_cnt - 8'd1;
    if (left_cnt == '0) begin
      want_check = 8'd0 - sum_acc;
      pstate     = ST_HUNT;
      r.kind     = KIND_END;
      r.plen     = frame_len - MinLen;
      if (b != EotByte) r.status = STAT_BAD_END;
      else if (want_check != rx_check) r.status = STAT_BAD_CHECK;
      else r.status = STAT_OK;
      return 1'b1;
    end
    if (left_cnt == 8'd1) begin
      rx_check = b;
      return 1'b0;
    end
    sum_acc = sum_acc + b;
    r.kind  = (pos == '0) ? KIND_ID : KIND_PAYLOAD;
    r.data  = b;
    return 1'b1;
  endfunction

  // one request per call, held until accepted
  task automatic send_byte(input logic [ByteW-1:0] b, input check_e how, input result_t lit);
    result_t r;
    bit      got;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    got = parse_byte(b, r);
    if (how == CHK_LIT) parsed_q.push_back(lit);
    else if (how == CHK_PRED && got) parsed_q.push_back(r);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (parsed_q.size() != 0);
  endtask

  task automatic send_frame();
    logic [ByteW-1:0] frame_q [$];
    logic [ByteW-1:0] len;
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    int               flaw;
    flaw = $urandom_range(0, 15);
    if (flaw == 5) begin
      repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
    end
    if (flaw == 3) begin
      b = ($urandom_range(0, 1) == 0) ? NullByte : 8'($urandom_range(2, 255));
      frame_q.push_back(NullByte);
      frame_q.push_back(b);
    end else if (flaw == 2) begin
      frame_q.push_back(NullByte);
      frame_q.push_back(SohByte);
      frame_q.push_back(8'($urandom_range(0, 2)));
    end else begin
      if ($urandom_range(0, 49) == 0) begin
        len = ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(200, 254));
      end else begin
        len = 8'($urandom_range(3, 12));
      end
      frame_q.push_back(NullByte);
      frame_q.push_back(SohByte);
      frame_q.push_back(len);
      sum = len;
      for (int i = 0; i < int'(len) - 2; i++) begin
        b   = 8'($urandom);
        sum = sum + b;
        frame_q.push_back(b);
      end
      b = 8'd0 - sum;
      if (flaw == 0) b = b ^ 8'($urandom_range(1, 255));
      frame_q.push_back(b);
      b = EotByte;
      if (flaw == 1) b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(5, 255))
                                                    : 8'($urandom_range(0, 3));
      frame_q.push_back(b);
      if (flaw == 4) begin
        repeat ($urandom_range(1, frame_q.size() - 3)) void'(frame_q.pop_back());
      end
    end
    foreach (frame_q[i]) send_byte(frame_q[i], CHK_PRED, '0);
    stream_items += frame_q.size();
  endtask

  task automatic report_mismatch(input string what, input result_t want);
    if (mismatch_count < 10) begin
      $display("%0t %s: expected kind %0d byte %02h status %0d len %0d,", $time, what,
               want.kind, want.data, want.status, want.plen);
      $display("    got kind %0d byte %02h status %0d len %0d",
               out_kind, out_byte, frame_status, payload_length);
    end
    mismatch_count++;
  endtask

  // receiver stall pattern, reloaded whenever the tick counter wraps
  always @(posedge clk) begin
    ready_tick <= ready_tick + 6'd1;
    if (ready_tick == '0) begin
      ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
    end
    out_ready <= ready_pattern[ready_tick[3:0]];
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (parsed_q.size() == 0) begin
          report_mismatch("result with none pending", '0);
        end else begin
          want = parsed_q.pop_front();
          if (out_kind !== want.kind || out_byte !== want.data ||
              frame_status !== want.status || payload_length !== want.plen) begin
            report_mismatch("mismatch", want);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DirectedRows[i]) begin
      send_byte(DirectedRows[i].rx, DirectedRows[i].how, DirectedRows[i].lit);
    end
    drain_results();
    while (stream_items < StreamItems) begin
      send_frame();
      if ($urandom_range(0, 39) == 0) drain_results();
    end
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0 && parsed_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
